### sv/dertlv_pkg.sv
package dertlv_pkg;

   // default geometry
   localparam int unsigned BUFFER_BYTES_DEF     = 65536;
   localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_HIGH_TAG   = 3'd1;
   localparam logic [2:0] STATUS_INDEFINITE = 3'd2;
   localparam logic [2:0] STATUS_LEN_LONG   = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;

   // universal tag numbers with extra decoding
   localparam logic [4:0] TAG_INTEGER    = 5'd2;
   localparam logic [4:0] TAG_BIT_STRING = 5'd3;
   localparam logic [4:0] TAG_HIGH_FORM  = 5'h1F;

   // header size limits
   localparam logic [2:0] HDR_MIN = 3'd2;
   localparam logic [2:0] HDR_MAX = 3'd6;

   // largest INTEGER content length that fits the value field
   localparam logic [31:0] INT_MAX_LEN = 32'd8;

endpackage

### sv/dertlv_req_if.sv
interface dertlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
   modport monitor (input valid, input data_byte, input last, input ready);
endinterface

### sv/dertlv_rsp_if.sv
interface dertlv_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  status;
   logic        [4:0]  tag_number;
   logic        [1:0]  tag_cls;
   logic               constructed;
   logic        [15:0] element_offset;
   logic        [2:0]  hdr_len;
   logic        [31:0] body_len;
   logic signed [63:0] int_value;
   logic               int_ok;
   logic        [34:0] bits_used;
   logic               bit_ok;

   modport source (output valid, output status, output tag_number, output tag_cls,
                   output constructed, output element_offset, output hdr_len,
                   output body_len, output int_value, output int_ok,
                   output bits_used, output bit_ok, input ready);
   modport sink (input valid, input status, input tag_number, input tag_cls,
                 input constructed, input element_offset, input hdr_len,
                 input body_len, input int_value, input int_ok,
                 input bits_used, input bit_ok, output ready);
   modport monitor (input valid, input status, input tag_number, input tag_cls,
                    input constructed, input element_offset, input hdr_len,
                    input body_len, input int_value, input int_ok,
                    input bits_used, input bit_ok, input ready);
endinterface

### sv/der_tlv_element_parser_top.sv
// a descriptor appears on rsp_port in the cycle after the byte that completes it
// throughput: one byte per cycle unless rsp stalls (single tag/length/content update)
// a new byte is taken while the output register drains (ready follows rsp ready)
// reset (synchronous, active high) returns to expecting a tag at buffer offset 0
// and empties the output register
module der_tlv_element_parser_top #(
   parameter int unsigned BUFFER_BYTES     = dertlv_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned MAX_LENGTH_BYTES = dertlv_pkg::MAX_LENGTH_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   dertlv_req_if.sink   req_port,
   dertlv_rsp_if.source rsp_port
);

   localparam int unsigned POS_W = $clog2(BUFFER_BYTES);

   // parse phases
   localparam logic [2:0] PH_TAG       = 3'd0;
   localparam logic [2:0] PH_LEN_FIRST = 3'd1;
   localparam logic [2:0] PH_LEN_MORE  = 3'd2;
   localparam logic [2:0] PH_CONTENT   = 3'd3;
   localparam logic [2:0] PH_HALT      = 3'd4;

   // parse state
   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       tag_ff, tag_in;
   logic [31:0]      len_ff, len_in;
   logic [2:0]       len_left_ff, len_left_in;
   logic [2:0]       hdr_ff, hdr_in;
   logic [31:0]      content_left_ff, content_left_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [63:0]      int_acc_ff, int_acc_in;
   logic [7:0]       first_ff, first_in;

   // output register
   logic               rsp_valid_ff;
   logic        [2:0]  status_ff;
   logic        [4:0]  tag_number_ff;
   logic        [1:0]  tag_cls_ff;
   logic               constructed_ff;
   logic        [15:0] offset_ff;
   logic        [2:0]  hdr_len_ff;
   logic        [31:0] body_len_ff;
   logic signed [63:0] int_value_ff;
   logic               int_ok_ff;
   logic        [34:0] bits_used_ff;
   logic               bit_ok_ff;

   logic        req_fire;
   logic        res_fire;
   logic        res_elem;
   logic [2:0]  res_status;
   logic [7:0]  b;
   logic [31:0] len_m1;
   logic [34:0] bit_full;
   logic        int_ok;
   logic        bit_ok;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_fire       = req_port.valid && req_port.ready;
   assign b              = req_port.data_byte;

   // next parse state and result decision
   always_comb begin
      phase_in        = phase_ff;
      tag_in          = tag_ff;
      len_in          = len_ff;
      len_left_in     = len_left_ff;
      hdr_in          = hdr_ff;
      content_left_in = content_left_ff;
      pos_in          = pos_ff;
      start_in        = start_ff;
      int_acc_in      = int_acc_ff;
      first_in        = first_ff;
      res_fire        = 1'b0;
      res_elem        = 1'b0;
      res_status      = dertlv_pkg::STATUS_OK;
      if (req_fire) begin
         pos_in = (pos_ff == POS_W'(BUFFER_BYTES - 1)) ? '0 : pos_ff + 1'b1;
         unique case (phase_ff)
            PH_TAG: begin
               start_in        = pos_ff;
               tag_in          = b;
               hdr_in          = 3'd1;
               len_in          = '0;
               content_left_in = '0;
               int_acc_in      = '0;
               first_in        = '0;
               if (req_port.last) begin
                  res_fire   = 1'b1;
                  res_status = dertlv_pkg::STATUS_TRUNCATED;
                  phase_in   = PH_HALT;
               end else if (b[4:0] == dertlv_pkg::TAG_HIGH_FORM) begin
                  res_fire   = 1'b1;
                  res_status = dertlv_pkg::STATUS_HIGH_TAG;
                  phase_in   = PH_HALT;
               end else begin
                  phase_in = PH_LEN_FIRST;
               end
            end
            PH_LEN_FIRST: begin
               hdr_in = 3'd2;
               if (!b[7]) begin
                  len_in          = 32'(b);
                  content_left_in = 32'(b);
                  if (b == 8'd0) begin
                     res_fire = 1'b1;
                     res_elem = 1'b1;
                     phase_in = PH_TAG;
                  end else begin
                     phase_in = PH_CONTENT;
                  end
               end else if (b[6:0] == 7'd0) begin
                  res_fire   = 1'b1;
                  res_status = dertlv_pkg::STATUS_INDEFINITE;
                  phase_in   = PH_HALT;
               end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                  res_fire   = 1'b1;
                  res_status = dertlv_pkg::STATUS_LEN_LONG;
                  phase_in   = PH_HALT;
               end else begin
                  len_left_in = b[2:0];
                  len_in      = '0;
                  phase_in    = PH_LEN_MORE;
               end
            end
            PH_LEN_MORE: begin
               len_in      = {len_ff[23:0], b};
               hdr_in      = hdr_ff + 3'd1;
               len_left_in = len_left_ff - 3'd1;
               if (len_left_in == 3'd0) begin
                  content_left_in = len_in;
                  if (len_in == 32'd0) begin
                     res_fire = 1'b1;
                     res_elem = 1'b1;
                     phase_in = PH_TAG;
                  end else begin
                     phase_in = PH_CONTENT;
                  end
               end
            end
            PH_CONTENT: begin
               if (content_left_ff == len_ff) begin
                  first_in   = b;
                  int_acc_in = {{56{b[7]}}, b};
               end else begin
                  int_acc_in = {int_acc_ff[55:0], b};
               end
               content_left_in = content_left_ff - 32'd1;
               if (content_left_in == 32'd0) begin
                  res_fire = 1'b1;
                  res_elem = 1'b1;
                  phase_in = PH_TAG;
               end
            end
            default: begin
               // halted after an error: drop bytes until the buffer ends
            end
         endcase
         // end of buffer: report an unfinished element, then restart
         if (req_port.last) begin
            if (!res_fire && phase_in != PH_TAG && phase_in != PH_HALT) begin
               res_fire   = 1'b1;
               res_status = dertlv_pkg::STATUS_TRUNCATED;
            end
            phase_in = PH_TAG;
            pos_in   = '0;
         end
      end
   end

   // INTEGER and BIT STRING decoding of the finished element
   assign len_m1   = len_in - 32'd1;
   assign bit_full = {len_m1, 3'b000};
   assign int_ok   = res_elem && tag_in[4:0] == dertlv_pkg::TAG_INTEGER &&
                     len_in != 32'd0 && len_in <= dertlv_pkg::INT_MAX_LEN;
   assign bit_ok   = res_elem && tag_in[4:0] == dertlv_pkg::TAG_BIT_STRING &&
                     len_in != 32'd0 && first_in[7:3] == 5'd0 &&
                     35'(first_in[2:0]) <= bit_full;

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
      tag_ff          <= tag_in;
      len_ff          <= len_in;
      len_left_ff     <= len_left_in;
      hdr_ff          <= hdr_in;
      content_left_ff <= content_left_in;
      start_ff        <= start_in;
      int_acc_ff      <= int_acc_in;
      first_ff        <= first_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_fire) begin
         status_ff      <= res_status;
         tag_number_ff  <= tag_in[4:0];
         tag_cls_ff     <= tag_in[7:6];
         constructed_ff <= tag_in[5];
         offset_ff      <= 16'(start_in);
         hdr_len_ff     <= res_elem ? hdr_in : 3'd0;
         body_len_ff    <= res_elem ? len_in : 32'd0;
         int_value_ff   <= int_ok ? $signed(int_acc_in) : 64'sd0;
         int_ok_ff      <= int_ok;
         bits_used_ff   <= bit_ok ? bit_full - 35'(first_in[2:0]) : 35'd0;
         bit_ok_ff      <= bit_ok;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = status_ff;
   assign rsp_port.tag_number     = tag_number_ff;
   assign rsp_port.tag_cls        = tag_cls_ff;
   assign rsp_port.constructed    = constructed_ff;
   assign rsp_port.element_offset = offset_ff;
   assign rsp_port.hdr_len        = hdr_len_ff;
   assign rsp_port.body_len       = body_len_ff;
   assign rsp_port.int_value      = int_value_ff;
   assign rsp_port.int_ok         = int_ok_ff;
   assign rsp_port.bits_used      = bits_used_ff;
   assign rsp_port.bit_ok         = bit_ok_ff;

endmodule

### sv/dertlv_checker.sv
module dertlv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_tag_number,
   input logic [15:0] rsp_element_offset,
   input logic [2:0]  rsp_hdr_len,
   input logic [31:0] rsp_body_len,
   input logic [63:0] rsp_int_value,
   input logic        rsp_int_ok,
   input logic        rsp_bit_ok
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // a stalled word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_element_offset) &&
         $stable(rsp_body_len) && $stable(rsp_int_value))
      else $error("rsp payload changed while stalled");

   // error words carry no element body
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dertlv_pkg::STATUS_OK |->
         rsp_hdr_len == 3'd0 && rsp_body_len == 32'd0 &&
         !rsp_int_ok && !rsp_bit_ok)
      else $error("error word with element fields set");

   // ok words have a header of tag plus length bytes
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dertlv_pkg::STATUS_OK |->
         rsp_hdr_len >= dertlv_pkg::HDR_MIN &&
         rsp_hdr_len <= dertlv_pkg::HDR_MAX)
      else $error("header size out of range");

   // value decodes only for their own tags and lengths
   a_decode_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (!rsp_int_ok || (rsp_tag_number == dertlv_pkg::TAG_INTEGER &&
            rsp_body_len != 32'd0 &&
            rsp_body_len <= dertlv_pkg::INT_MAX_LEN)) &&
         (!rsp_bit_ok || (rsp_tag_number == dertlv_pkg::TAG_BIT_STRING &&
            rsp_body_len != 32'd0)))
      else $error("int_ok or bit_ok set for wrong tag or length");

endmodule

bind der_tlv_element_parser_top dertlv_checker u_dertlv_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_status         (rsp_port.status),
   .rsp_tag_number     (rsp_port.tag_number),
   .rsp_element_offset (rsp_port.element_offset),
   .rsp_hdr_len        (rsp_port.hdr_len),
   .rsp_body_len       (rsp_port.body_len),
   .rsp_int_value      (rsp_port.int_value),
   .rsp_int_ok         (rsp_port.int_ok),
   .rsp_bit_ok         (rsp_port.bit_ok)
);
